FILE: sv/stc_pkg.sv
// Package with compare codes, register indexes and lane helpers for the stencil texel converter.
package stc_pkg;

  typedef enum logic [2:0] {
    CMP_NEVER    = 3'd0,
    CMP_LESS     = 3'd1,
    CMP_EQUAL    = 3'd2,
    CMP_LEQUAL   = 3'd3,
    CMP_GREATER  = 3'd4,
    CMP_NOTEQUAL = 3'd5,
    CMP_GEQUAL   = 3'd6,
    CMP_ALWAYS   = 3'd7
  } cmp_func_e;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMPARE_FUNC    = 2'd0,
    REG_REFERENCE_VALUE = 2'd1,
    REG_READ_MASK       = 2'd2,
    REG_EIGHT_BIT_MODE  = 2'd3
  } cfg_reg_e;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned NumBytes = WordW / ByteW;
  localparam int unsigned NumNibs  = WordW / NibW;

  localparam logic [ByteW-1:0] ByteMax = 8'hff;
  localparam logic [ByteW-1:0] NibMax  = 8'h0f;

  typedef struct packed {
    cmp_func_e        func;
    logic [ByteW-1:0] mask;
    logic [ByteW-1:0] mref;
    logic             wide;
  } stc_ctrl_t;

endpackage

FILE: sv/stc_lane_logic.sv
// Combinational per-lane stencil conversion and output-needed decision.
module stc_lane_logic (
  input  stc_pkg::stc_ctrl_t          ctrl_i,
  input  logic [stc_pkg::WordW-1:0]   word_i,
  output logic                        needed_o,
  output logic [stc_pkg::WordW-1:0]   texel_o
);

  logic [stc_pkg::WordW-1:0] neq_bytes;
  logic [stc_pkg::WordW-1:0] neq_nibs;
  logic [stc_pkg::WordW-1:0] wmask;
  logic [stc_pkg::NibW-1:0]  mask_nib;
  logic [stc_pkg::NibW-1:0]  mref_nib;

  assign mask_nib = ctrl_i.mask[stc_pkg::NibW-1:0];
  assign mref_nib = ctrl_i.mref[stc_pkg::NibW-1:0];

  always_comb begin
    neq_bytes = '0;
    for (int i = 0; i < stc_pkg::NumBytes; i++) begin
      neq_bytes[i*stc_pkg::ByteW] =
        ((word_i[i*stc_pkg::ByteW +: stc_pkg::ByteW] & ctrl_i.mask) != ctrl_i.mref);
    end
  end

  always_comb begin
    neq_nibs = '0;
    for (int i = 0; i < stc_pkg::NumNibs; i++) begin
      neq_nibs[i*stc_pkg::NibW] =
        ((word_i[i*stc_pkg::NibW +: stc_pkg::NibW] & mask_nib) != mref_nib);
    end
  end

  assign wmask = ctrl_i.wide ? {stc_pkg::NumBytes{ctrl_i.mask}}
                             : {stc_pkg::NumNibs{mask_nib}};

  always_comb begin
    unique case (ctrl_i.func)
      stc_pkg::CMP_ALWAYS,
      stc_pkg::CMP_NEVER:  needed_o = 1'b0;
      stc_pkg::CMP_GEQUAL: needed_o = (ctrl_i.mref != '0);
      stc_pkg::CMP_LEQUAL: needed_o = ctrl_i.wide ? (ctrl_i.mref != stc_pkg::ByteMax)
                                                  : (ctrl_i.mref != stc_pkg::NibMax);
      default:             needed_o = 1'b1;
    endcase
  end

  assign texel_o = (ctrl_i.func == stc_pkg::CMP_NOTEQUAL)
                 ? (ctrl_i.wide ? neq_bytes : neq_nibs)
                 : (word_i & wmask);

endmodule

FILE: sv/stencil_texel_converter.sv
// Top level of the stencil texel converter: config registers, input and result registers.
// Usage:
//   Configuration: write cfg_index_i/cfg_data_i with cfg_valid_i; cfg_ready_o is always
//   high, so each write is taken when it is presented. Indexes beyond the register list
//   are dropped. Write only while the block is idle.
//   Command channel: present stencil_word_i with start_i; it is taken when busy_o is
//   low. busy_o stays low, so one word is accepted every cycle.
//   Results: texel_word_o is shown for one cycle with done_o high, once the word has
//   passed the input register, then the result register. Words whose compare case
//   needs no texture produce no done_o pulse.
//   Throughput is one word per cycle: the lane compare and masking logic sits in a
//   single stage between the input register and the result register.
//   The receiver cannot stall; every result is taken in the cycle it is shown.
//   Reset (rst_ni low, asynchronous) clears the pipeline valid flags and loads the
//   register defaults: compare always, reference 0, read mask 0xff, 4-bit mode.
module stencil_texel_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [stc_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [stc_pkg::WordW-1:0]     stencil_word_i,
  output logic                          done_o,
  output logic [stc_pkg::WordW-1:0]     texel_word_o
);

  stc_pkg::cmp_func_e        compare_func_q;
  logic [stc_pkg::ByteW-1:0] reference_value_q;
  logic [stc_pkg::ByteW-1:0] read_mask_q;
  logic                      eight_bit_mode_q;

  logic                      in_valid_q;
  logic [stc_pkg::WordW-1:0] in_word_q;
  logic                      out_valid_q;
  logic [stc_pkg::WordW-1:0] out_word_q;

  stc_pkg::stc_ctrl_t        ctrl;
  logic                      needed;
  logic [stc_pkg::WordW-1:0] texel_d;
  logic                      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compare_func_q    <= stc_pkg::CMP_ALWAYS;
      reference_value_q <= '0;
      read_mask_q       <= stc_pkg::ByteMax;
      eight_bit_mode_q  <= 1'b0;
    end else if (cfg_we) begin
      unique case (stc_pkg::cfg_reg_e'(cfg_index_i))
        stc_pkg::REG_COMPARE_FUNC:    compare_func_q    <= stc_pkg::cmp_func_e'(cfg_data_i[2:0]);
        stc_pkg::REG_REFERENCE_VALUE: reference_value_q <= cfg_data_i;
        stc_pkg::REG_READ_MASK:       read_mask_q       <= cfg_data_i;
        stc_pkg::REG_EIGHT_BIT_MODE:  eight_bit_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ctrl.func = compare_func_q;
    ctrl.wide = eight_bit_mode_q;
    ctrl.mask = eight_bit_mode_q ? read_mask_q : (read_mask_q & stc_pkg::NibMax);
    ctrl.mref = reference_value_q & ctrl.mask;
  end

  stc_lane_logic u_lane (
    .ctrl_i   (ctrl),
    .word_i   (in_word_q),
    .needed_o (needed),
    .texel_o  (texel_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start_i & ~busy_o;
      out_valid_q <= in_valid_q & needed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_word_q <= stencil_word_i;
    end
    if (in_valid_q) begin
      out_word_q <= texel_d;
    end
  end

  assign done_o       = out_valid_q;
  assign texel_word_o = out_word_q;

endmodule

FILE: sv/stc_checker.sv
// Port-level assertions for the stencil texel converter, bound to the top level.
module stc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [stc_pkg::WordW-1:0]   texel_word_o
);

  a_done_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2) && !$past(busy_o, 2))
    else $error("result without an accepted word two cycles earlier");

  a_no_done_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o)
    else $error("result right after reset");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("block refused a word");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

  a_done_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(texel_word_o) || $past(start_i, 2))
    else $error("result word unknown");

endmodule

bind stencil_texel_converter stc_checker u_stc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .texel_word_o (texel_word_o)
);
